// ===== sv/midirsp_pkg.sv =====
package midirsp_pkg;

  // parser states: which byte is expected next
  typedef enum logic [3:0] {
    ST_IGNORE = 4'd0,
    ST_NON_1  = 4'd1,
    ST_NON_2  = 4'd2,
    ST_NOFF_1 = 4'd3,
    ST_NOFF_2 = 4'd4,
    ST_PROG   = 4'd5,
    ST_CC_1   = 4'd6,
    ST_CC_2   = 4'd7,
    ST_PW_1   = 4'd8,
    ST_PW_2   = 4'd9
  } parse_state_t;

  // message kinds reported on the result channel
  typedef enum logic [2:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_PROGRAM  = 3'd2,
    KIND_CONTROL  = 3'd3,
    KIND_PITCH    = 3'd4
  } msg_kind_t;

  // high nibble of the channel status bytes we decode
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_CONTROL  = 4'hB;
  localparam logic [3:0] STATUS_PROGRAM  = 4'hC;
  localparam logic [3:0] STATUS_PITCH    = 4'hE;

  localparam logic [3:0] LISTEN_CHANNEL_RESET = 4'd0;

  // decode of one received byte
  typedef struct packed {
    parse_state_t state_next;
    logic         hold_load;
    logic         emit;
    msg_kind_t    kind;
    logic [6:0]   first_data;
    logic [6:0]   second_data;
  } decode_t;

endpackage

// ===== sv/midi_running_status_parser_unit.sv =====
// MIDI running-status receive parser.
// Input channel: one received byte per transfer on rx_byte (in_valid/in_ready).
// Status bytes on the listened channel arm the parser for note on, note off,
// program change, control change or pitch wheel; data bytes then build
// messages under running status. Every other status byte (other channels,
// other kinds, system and real-time bytes) puts the parser in its ignore state.
// Result channel: msg_kind, first_data, second_data (out_valid/out_ready),
// one transfer per completed message; a zero velocity note on comes out as
// a note off. Configuration channel: cfg_data writes the listened channel
// (cfg_valid/cfg_ready, always ready); write only while the parser is idle.
// A completing byte shows its result in the cycle after its transfer.
// Throughput: one byte per cycle, set by the single output register; a byte
// is taken whenever that register is empty or being drained in the same cycle.
// When the receiver stalls with a result pending, in_ready drops until it is
// taken. Reset (synchronous rst) clears the parser to the ignore state, the
// held data byte to zero, the listened channel to 0 and the output empty.
module midi_running_status_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] msg_kind,
  output logic [6:0] first_data,
  output logic [6:0] second_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);
  import midirsp_pkg::*;

  parse_state_t parse_state;
  logic [6:0]   held_first_byte;
  logic [3:0]   listen_channel;
  decode_t      dec;
  logic         in_fire;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  midirsp_decode u_decode (
    .state           (parse_state),
    .held_first_byte (held_first_byte),
    .listen_channel  (listen_channel),
    .rx_byte         (rx_byte),
    .dec             (dec)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= LISTEN_CHANNEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      listen_channel <= cfg_data;
    end
  end

  // parser state and held first data byte
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= ST_IGNORE;
      held_first_byte <= 7'd0;
    end else if (in_fire) begin
      parse_state <= dec.state_next;
      if (dec.hold_load) begin
        held_first_byte <= rx_byte[6:0];
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && dec.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_fire && dec.emit) begin
      msg_kind    <= dec.kind;
      first_data  <= dec.first_data;
      second_data <= dec.second_data;
    end
  end

  // program change always carries zero second data
  a_prog_second_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && msg_kind == KIND_PROGRAM) |-> second_data == 7'd0)
    else $error("program change with nonzero second data");

  // a note on result never carries zero velocity
  a_note_on_velocity: assert property (@(posedge clk) disable iff (rst)
    (out_valid && msg_kind == KIND_NOTE_ON) |-> second_data != 7'd0)
    else $error("note on with zero velocity");

  // a status byte for another channel disarms the parser
  a_other_channel: assert property (@(posedge clk) disable iff (rst)
    (in_fire && rx_byte[7] && rx_byte[3:0] != listen_channel)
      |=> parse_state == ST_IGNORE)
    else $error("foreign status byte did not disarm parser");

  // data bytes while ignoring stay ignored and give no result
  a_ignore_data: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !rx_byte[7] && parse_state == ST_IGNORE)
      |=> (parse_state == ST_IGNORE && !$rose(out_valid)))
    else $error("data byte left ignore state or produced a result");

  // the output is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result pending");

endmodule

// ===== sv/midirsp_decode.sv =====
module midirsp_decode (
  input  midirsp_pkg::parse_state_t state,
  input  logic [6:0]                held_first_byte,
  input  logic [3:0]                listen_channel,
  input  logic [7:0]                rx_byte,
  output midirsp_pkg::decode_t      dec
);
  import midirsp_pkg::*;

  logic         is_status;
  logic [6:0]   data;
  parse_state_t state_next;

  assign is_status = rx_byte[7];
  assign data      = rx_byte[6:0];

  // next state: status bytes arm or disarm, data bytes step under running status
  always_comb begin
    state_next = ST_IGNORE;
    if (is_status) begin
      if (rx_byte[3:0] == listen_channel) begin
        unique case (rx_byte[7:4])
          STATUS_NOTE_ON:  state_next = ST_NON_1;
          STATUS_NOTE_OFF: state_next = ST_NOFF_1;
          STATUS_PROGRAM:  state_next = ST_PROG;
          STATUS_PITCH:    state_next = ST_PW_1;
          STATUS_CONTROL:  state_next = ST_CC_1;
          default:         state_next = ST_IGNORE;
        endcase
      end
    end else begin
      unique case (state)
        ST_NON_1:  state_next = ST_NON_2;
        ST_NON_2:  state_next = ST_NON_1;
        ST_NOFF_1: state_next = ST_NOFF_2;
        ST_NOFF_2: state_next = ST_NOFF_1;
        ST_PROG:   state_next = ST_PROG;
        ST_CC_1:   state_next = ST_CC_2;
        ST_CC_2:   state_next = ST_CC_1;
        ST_PW_1:   state_next = ST_PW_2;
        ST_PW_2:   state_next = ST_PW_1;
        default:   state_next = ST_IGNORE;
      endcase
    end
  end

  // outputs: latch first data byte or complete a message
  always_comb begin
    dec.state_next  = state_next;
    dec.hold_load   = 1'b0;
    dec.emit        = 1'b0;
    dec.kind        = KIND_NOTE_ON;
    dec.first_data  = held_first_byte;
    dec.second_data = data;
    if (!is_status) begin
      unique case (state)
        ST_NON_1, ST_NOFF_1, ST_CC_1, ST_PW_1: dec.hold_load = 1'b1;
        ST_NON_2: begin
          dec.emit = 1'b1;
          // zero velocity note on is a note off
          dec.kind = (data == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
        end
        ST_NOFF_2: begin
          dec.emit = 1'b1;
          dec.kind = KIND_NOTE_OFF;
        end
        ST_PROG: begin
          dec.emit        = 1'b1;
          dec.kind        = KIND_PROGRAM;
          dec.first_data  = data;
          dec.second_data = 7'd0;
        end
        ST_CC_2: begin
          dec.emit = 1'b1;
          dec.kind = KIND_CONTROL;
        end
        ST_PW_2: begin
          dec.emit = 1'b1;
          dec.kind = KIND_PITCH;
        end
        default: dec.hold_load = 1'b0;
      endcase
    end
  end

endmodule
